@@ rtl/core/nfo_pkg.sv @@
package nfo_pkg;

   typedef struct packed {
      logic signed [15:0] v_alpha;
      logic signed [15:0] v_beta;
      logic signed [15:0] i_alpha;
      logic signed [15:0] i_beta;
   } req_type;

   typedef struct packed {
      logic signed [15:0] angle_est;
      logic signed [31:0] speed_est;
      logic signed [31:0] flux_alpha_est;
      logic signed [31:0] flux_beta_est;
      logic [30:0]        flux_magnitude_est;
   } rsp_type;

   localparam logic [2:0] REG_RESISTANCE = 3'd0;
   localparam logic [2:0] REG_INDUCTANCE = 3'd1;
   localparam logic [2:0] REG_NOM_FLUX   = 3'd2;
   localparam logic [2:0] REG_GAIN       = 3'd3;
   localparam logic [2:0] REG_TS         = 3'd4;
   localparam logic [2:0] REG_PLL_KP     = 3'd5;
   localparam logic [2:0] REG_PLL_KI     = 3'd6;

   localparam logic [31:0] TS_RESET = 32'd214748;
   localparam logic [15:0] KP_RESET = 16'd800;
   localparam logic [19:0] KI_RESET = 20'd20000;

   localparam logic signed [32:0] Q_ADAPT_RATE = 33'sd13107;
   localparam logic signed [32:0] Q_LOW_LIMIT  = 33'sd19661;
   localparam logic signed [32:0] Q_BOOST      = 33'sd72090;
   localparam logic signed [32:0] INV_TWO_PI   = 33'sd683565276;
   localparam logic signed [32:0] SIN_A1       = 33'sd25736;
   localparam logic signed [32:0] SIN_A3       = 33'sd10512;
   localparam logic signed [32:0] SIN_A5       = 33'sd1160;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      logic signed [31:0] r;
      if (x > 66'sh0_7FFF_FFFF)
         r = 32'sh7FFF_FFFF;
      else if (x < -66'sh0_8000_0000)
         r = -32'sh8000_0000;
      else
         r = x[31:0];
      return r;
   endfunction

   // fold a turn fraction onto the quarter wave around zero
   function automatic logic signed [16:0] fold_q(input logic [15:0] a);
      logic signed [17:0] s;
      logic signed [17:0] r;
      s = 18'($signed(a));
      if (s > 18'sd16384)
         r = 18'sd32768 - s;
      else if (s < -18'sd16384)
         r = -18'sd32768 - s;
      else
         r = s;
      return r[16:0];
   endfunction

endpackage

@@ rtl/core/nonlinear_flux_observer_pll.sv @@
// channel  direction  handshake                  payload
// req      in         req_valid / req_ready      req_data  (v, i alpha/beta)
// rsp      out        rsp_valid / rsp_ready      rsp_data  (angle, speed, flux)
// csr      in         csr_valid / csr_ready      csr_index, csr_data
//
// a sample runs from acceptance to its result beat through steps around the
// shared 33x33 multiplier and a restoring divider for the pll error (the divider
// is skipped when the flux magnitude is zero).
// synchronous active-high reset clears the states and loads register defaults.
// req_ready is high only when idle, from the same cycle that the result loads; a beat that
// is not taken holds the sequencer at its last step until rsp_ready.
module nonlinear_flux_observer_pll (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  nfo_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output nfo_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import nfo_pkg::*;

   localparam logic [5:0] ST_IDLE = 6'd0,  ST_LIA = 6'd1,  ST_LIB = 6'd2,  ST_LAM2 = 6'd3;
   localparam logic [5:0] ST_X1SQ = 6'd4,  ST_X2SQ = 6'd5, ST_ERR = 6'd6,  ST_G1 = 6'd7;
   localparam logic [5:0] ST_G2 = 6'd8,    ST_G3 = 6'd9,   ST_G4 = 6'd10,  ST_LAMU = 6'd11;
   localparam logic [5:0] ST_LO = 6'd12,   ST_E1 = 6'd13,  ST_E2 = 6'd14,  ST_E3 = 6'd15;
   localparam logic [5:0] ST_E4 = 6'd16,   ST_E5 = 6'd17,  ST_E6 = 6'd18,  ST_E7 = 6'd19;
   localparam logic [5:0] ST_E8 = 6'd20,   ST_E9 = 6'd21,  ST_E10 = 6'd22, ST_E11 = 6'd23;
   localparam logic [5:0] ST_M1 = 6'd24,   ST_M2 = 6'd25,  ST_M3 = 6'd26,  ST_B1 = 6'd27;
   localparam logic [5:0] ST_B2 = 6'd28,   ST_B3 = 6'd29,  ST_S0 = 6'd30,  ST_S1 = 6'd31;
   localparam logic [5:0] ST_S2 = 6'd32,   ST_S3 = 6'd33,  ST_S4 = 6'd34,  ST_N0 = 6'd35;
   localparam logic [5:0] ST_N1 = 6'd36,   ST_N2 = 6'd37,  ST_N3 = 6'd38,  ST_DIV = 6'd39;
   localparam logic [5:0] ST_DIVE = 6'd40, ST_K1 = 6'd41,  ST_K2 = 6'd42,  ST_K3 = 6'd43;
   localparam logic [5:0] ST_K4 = 6'd44,   ST_K5 = 6'd45,  ST_K6 = 6'd46,  ST_K7 = 6'd47;
   localparam logic [5:0] ST_K8 = 6'd48;

   // configuration
   logic [15:0] res_ff, ind_ff, kp_ff;
   logic [30:0] nom_ff;
   logic [31:0] gain_ff, ts_ff;
   logic [19:0] ki_ff;

   // persistent state
   logic signed [31:0] x1_ff, x2_ff, lam_ff, integ_ff;
   logic [15:0]        angle_ff;

   // working registers
   logic [5:0]         step_ff;
   logic               cos_ff, weak_ff, neg_ff;
   logic signed [15:0] va_ff, vb_ff, ia_ff, ib_ff;
   logic signed [31:0] lia_ff, lib_ff, lamt_ff, errc_ff, ea_ff, eb_ff, g_ff, xd_ff;
   logic signed [31:0] x1n_ff, x2n_ff, da_ff, db_ff, oe_ff, kpv_ff, spd_ff;
   logic signed [40:0] err_ff;
   logic [63:0]        m2_ff;
   logic [15:0]        z2_ff;
   logic signed [16:0] s_ff;
   logic signed [15:0] sn_ff, cs_ff;
   logic signed [47:0] num_ff;
   logic [49:0]        dvn_ff, quo_ff;
   logic [30:0]        rem_ff;
   logic [5:0]         cnt_ff;
   logic signed [65:0] prod_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_in;

   // shared multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         ST_LIA:  begin mul_a = 33'($signed({1'b0, ind_ff})); mul_b = 33'(ia_ff); end
         ST_LIB:  begin mul_a = 33'($signed({1'b0, ind_ff})); mul_b = 33'(ib_ff); end
         ST_LAM2: begin mul_a = 33'(lam_ff); mul_b = 33'(lam_ff); end
         ST_X1SQ: begin mul_a = 33'(x1_ff); mul_b = 33'(x1_ff); end
         ST_X2SQ: begin mul_a = 33'(x2_ff); mul_b = 33'(x2_ff); end
         ST_G1:   begin mul_a = 33'(lam_ff); mul_b = 33'(sat32(-66'(err_ff))); end
         ST_G2, ST_E2, ST_E7: begin
            mul_a = 33'($signed({1'b0, gain_ff}));
            mul_b = 33'(sat32(prod_ff >>> 24));
         end
         ST_G3:   begin mul_a = 33'(sat32(prod_ff >>> 9)); mul_b = Q_ADAPT_RATE; end
         ST_G4:   begin mul_a = 33'($signed(prod_ff[47:16])); mul_b = $signed({1'b0, ts_ff}); end
         ST_LAMU: begin mul_a = 33'($signed({1'b0, nom_ff})); mul_b = Q_LOW_LIMIT; end
         ST_E1:   begin mul_a = 33'(ea_ff); mul_b = 33'(errc_ff); end
         ST_E3:   begin mul_a = 33'($signed({1'b0, res_ff})); mul_b = 33'(ia_ff); end
         ST_E5, ST_E10: begin mul_a = 33'(xd_ff); mul_b = $signed({1'b0, ts_ff}); end
         ST_E6:   begin mul_a = 33'(eb_ff); mul_b = 33'(errc_ff); end
         ST_E8:   begin mul_a = 33'($signed({1'b0, res_ff})); mul_b = 33'(ib_ff); end
         ST_E11:  begin mul_a = 33'(x1n_ff); mul_b = 33'(x1n_ff); end
         ST_M1:   begin mul_a = 33'(x2n_ff); mul_b = 33'(x2n_ff); end
         ST_M2: begin
            mul_a = 33'($signed({1'b0, nom_ff}));
            mul_b = 33'($signed({1'b0, nom_ff}));
         end
         ST_M3:   begin mul_a = 33'(x1n_ff); mul_b = Q_BOOST; end
         ST_B1:   begin mul_a = 33'(x2n_ff); mul_b = Q_BOOST; end
         ST_S0:   begin mul_a = 33'(s_ff); mul_b = 33'(s_ff); end
         ST_S1:   begin mul_a = 33'($signed({1'b0, prod_ff[29:14]})); mul_b = SIN_A5; end
         ST_S2: begin
            mul_a = 33'($signed({1'b0, z2_ff}));
            mul_b = SIN_A3 - 33'($signed({1'b0, prod_ff[31:14]}));
         end
         ST_S3: begin
            mul_a = 33'(s_ff);
            mul_b = SIN_A1 - 33'($signed(prod_ff[45:14]));
         end
         ST_N0:   begin mul_a = 33'(db_ff); mul_b = 33'(cs_ff); end
         ST_N1:   begin mul_a = 33'(da_ff); mul_b = 33'(sn_ff); end
         ST_K1:   begin mul_a = 33'($signed({1'b0, kp_ff})); mul_b = 33'(oe_ff); end
         ST_K2:   begin mul_a = 33'($signed({1'b0, ki_ff})); mul_b = 33'(oe_ff); end
         ST_K3:   begin mul_a = 33'(sat32(prod_ff)); mul_b = $signed({1'b0, ts_ff}); end
         ST_K6:   begin mul_a = 33'(spd_ff); mul_b = $signed({1'b0, ts_ff}); end
         ST_K7:   begin mul_a = 33'($signed(prod_ff[63:32])); mul_b = INV_TWO_PI; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   assign prod_in = 66'(mul_a) * 66'(mul_b);

   // adaptive flux clamp limits
   logic [30:0]        lo_v, hi_v;
   logic [33:0]        hi5;
   logic signed [31:0] lam_c;
   always_comb begin
      lo_v = prod_ff[46:16];
      hi5  = {1'b0, nom_ff, 2'b00} + {3'b000, nom_ff};
      hi_v = (hi5[33:32] != 2'b00) ? 31'h7FFF_FFFF : hi5[31:1];
      if (lamt_ff < $signed({1'b0, lo_v}))
         lam_c = $signed({1'b0, lo_v});
      else if (lamt_ff > $signed({1'b0, hi_v}))
         lam_c = $signed({1'b0, hi_v});
      else
         lam_c = lamt_ff;
   end

   // divider step and observer sums
   logic [31:0]        rem_sh, rem_df;
   logic               rem_ge;
   logic signed [49:0] num_x, num_abs;
   logic signed [65:0] quo_s, xd_sum, dturn;
   always_comb begin
      rem_sh  = {rem_ff, dvn_ff[49]};
      rem_df  = rem_sh - {1'b0, lamt_ff[30:0]};
      rem_ge  = rem_sh >= {1'b0, lamt_ff[30:0]};
      num_x   = 50'(num_ff);
      num_abs = num_x[49] ? -num_x : num_x;
      quo_s   = neg_ff ? -$signed({16'd0, quo_ff}) : $signed({16'd0, quo_ff});
      xd_sum  = (step_ff == ST_E9) ? (66'(vb_ff) <<< 12) : (66'(va_ff) <<< 12);
      xd_sum  = xd_sum - prod_ff + 66'(g_ff);
      dturn   = (prod_ff + 66'sd2147483648) >>> 32;
   end

   assign req_ready = (step_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
         ind_ff <= '0;
         nom_ff <= '0;
         gain_ff <= '0;
         ts_ff <= TS_RESET;
         kp_ff <= KP_RESET;
         ki_ff <= KI_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RESISTANCE: res_ff  <= csr_data[15:0];
            REG_INDUCTANCE: ind_ff  <= csr_data[15:0];
            REG_NOM_FLUX:   nom_ff  <= csr_data[30:0];
            REG_GAIN:       gain_ff <= csr_data;
            REG_TS:         ts_ff   <= csr_data;
            REG_PLL_KP:     kp_ff   <= csr_data[15:0];
            REG_PLL_KI:     ki_ff   <= csr_data[19:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (step_ff != ST_K8 && step_ff != ST_DIV)
         prod_ff <= prod_in;
      case (step_ff)
         ST_IDLE: begin
            va_ff <= req_data.v_alpha;
            vb_ff <= req_data.v_beta;
            ia_ff <= req_data.i_alpha;
            ib_ff <= req_data.i_beta;
            // working copy of the flux magnitude starts from the stored state
            lamt_ff <= lam_ff;
         end
         ST_LIB:  lia_ff <= sat32(prod_ff >>> 12);
         ST_LAM2: lib_ff <= sat32(prod_ff >>> 12);
         ST_X1SQ: err_ff <= $signed(prod_ff[64:24]);
         ST_X2SQ, ST_ERR: err_ff <= err_ff - $signed(prod_ff[64:24]);
         ST_LAMU: lamt_ff <= sat32(66'(lamt_ff) + (prod_ff >>> 32));
         ST_LO: begin
            lamt_ff <= lam_c;
            errc_ff <= err_ff[40] ? sat32(66'(err_ff)) : '0;
            ea_ff   <= sat32(66'(x1_ff) - 66'(lia_ff));
            eb_ff   <= sat32(66'(x2_ff) - 66'(lib_ff));
         end
         ST_E3, ST_E8: g_ff <= sat32(prod_ff >>> 9);
         ST_E4, ST_E9: xd_ff <= sat32(xd_sum);
         ST_E6:  x1n_ff <= sat32(66'(x1_ff) + (prod_ff >>> 32));
         ST_E11: x2n_ff <= sat32(66'(x2_ff) + (prod_ff >>> 32));
         ST_M1:  m2_ff <= prod_ff[63:0];
         ST_M2:  m2_ff <= m2_ff + prod_ff[63:0];
         ST_M3:  weak_ff <= (m2_ff[63:62] == 2'b00) && ({m2_ff[61:0], 2'b00} < prod_ff[63:0]);
         ST_B1:  if (weak_ff) x1n_ff <= sat32(prod_ff >>> 16);
         ST_B2:  if (weak_ff) x2n_ff <= sat32(prod_ff >>> 16);
         ST_B3: begin
            da_ff  <= sat32(66'(x1n_ff) - 66'(lia_ff));
            db_ff  <= sat32(66'(x2n_ff) - 66'(lib_ff));
            s_ff   <= fold_q(angle_ff);
            cos_ff <= 1'b0;
         end
         ST_S1: z2_ff <= prod_ff[29:14];
         ST_S4: begin
            if (!cos_ff) begin
               sn_ff  <= prod_ff[29:14];
               s_ff   <= fold_q(angle_ff + 16'd16384);
               cos_ff <= 1'b1;
            end else begin
               cs_ff <= prod_ff[29:14];
            end
         end
         ST_N1: num_ff <= prod_ff[47:0];
         ST_N2: num_ff <= num_ff - prod_ff[47:0];
         ST_N3: begin
            dvn_ff <= num_abs[49:0] << 2;
            neg_ff <= num_x[49];
            rem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= '0;
            oe_ff  <= '0;
         end
         ST_DIV: begin
            rem_ff <= rem_ge ? rem_df[30:0] : rem_sh[30:0];
            quo_ff <= {quo_ff[48:0], rem_ge};
            dvn_ff <= dvn_ff << 1;
            cnt_ff <= cnt_ff + 6'd1;
         end
         ST_DIVE: oe_ff <= sat32(quo_s);
         ST_K2: kpv_ff <= sat32(prod_ff);
         ST_K5: spd_ff <= sat32(66'(kpv_ff) + 66'(integ_ff));
         default: ;
      endcase
   end

   // sequencer and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         lam_ff       <= '0;
         integ_ff     <= '0;
         angle_ff     <= '0;
      end else begin
         if (rsp_valid_ff && rsp_ready && step_ff != ST_K8)
            rsp_valid_ff <= 1'b0;
         case (step_ff)
            ST_IDLE: if (req_valid) step_ff <= ST_LIA;
            ST_N3:   step_ff <= (lamt_ff > 32'sd0) ? ST_DIV : ST_K1;
            ST_DIV:  if (cnt_ff == 6'd49) step_ff <= ST_DIVE;
            ST_S4:   step_ff <= cos_ff ? ST_N0 : ST_S0;
            ST_K4: begin
               integ_ff <= sat32(66'(integ_ff) + (prod_ff >>> 32));
               step_ff  <= ST_K5;
            end
            ST_K8: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  angle_ff <= angle_ff + dturn[15:0];
                  x1_ff    <= x1n_ff;
                  x2_ff    <= x2n_ff;
                  lam_ff   <= lamt_ff;
                  rsp_valid_ff                    <= 1'b1;
                  rsp_data_ff.angle_est           <= $signed(angle_ff + dturn[15:0]);
                  rsp_data_ff.speed_est           <= spd_ff;
                  rsp_data_ff.flux_alpha_est      <= da_ff;
                  rsp_data_ff.flux_beta_est       <= db_ff;
                  rsp_data_ff.flux_magnitude_est  <= lamt_ff[30:0];
                  step_ff  <= ST_IDLE;
               end
            end
            default: step_ff <= step_ff + 6'd1;
         endcase
      end
   end

`ifndef SYNTH
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step_ff) == ST_K8)
      else $error("result beat raised outside the final step");
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> step_ff == ST_LIA)
      else $error("accepted sample did not start the sequence");
   a_lam_pos: assert property (@(posedge clock) disable iff (reset)
      !lam_ff[31])
      else $error("flux magnitude went negative");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      step_ff == ST_DIV |-> cnt_ff <= 6'd49)
      else $error("divider ran past its last bit");
`endif

endmodule
